// File: rtl/tql_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tql_pkg
// Shared constants and types for the tabular Q-learning engine.
// -----------------------------------------------------------------------------
package tql_pkg;

  localparam int NUM_STATES  = 64;
  localparam int NUM_ACTIONS = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int STATE_W     = 6;
  localparam int ACTION_W    = 3;
  localparam int ADDR_W      = STATE_W + ACTION_W;
  localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;
  localparam int RATE_W      = 16;
  localparam int DIV_W       = RATE_W + ACTION_W;

  // signed value: VALUE_WIDTH; product widths
  localparam int PROD_W      = VALUE_WIDTH + RATE_W + 2;
  localparam int SUM_W       = VALUE_WIDTH + 3;

  localparam logic [1:0] REG_EXPLORE  = 2'd0;
  localparam logic [1:0] REG_DISCOUNT = 2'd1;
  localparam logic [1:0] REG_LEARN    = 2'd2;

  localparam logic [RATE_W-1:0] EXPLORE_RESET  = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET = 16'd58982;
  localparam logic [RATE_W-1:0] LEARN_RESET    = 16'd6554;

  localparam logic MODE_SELECT = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

endpackage
`default_nettype wire

// File: rtl/tabular_q_learning_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tabular_q_learning_engine
// Epsilon-greedy action select and Q-table update on one shared datapath.
// -----------------------------------------------------------------------------
// Clear pass after reset writes all 512 table entries, no request accepted meanwhile.
// Explore select: bit-serial divide of 19 steps, then result.
// Greedy select: row scan, one table read per cycle.
// Update: scan of next row, two multiplies, write-back.
// One request in flight; a result register lets the next request in early.
// -----------------------------------------------------------------------------
module tabular_q_learning_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // tdata: rand_frac[15:0], taken_action[18:16], dest_state[24:19],
  //        reward[56:25], zero pad to 64
  input  wire  [63:0] s_tdata,
  // tuser: mode
  input  wire         s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // tdata: action[2:0], explored[3], zero pad to 8
  output logic [7:0]  m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = tql_pkg::ADDR_W;
  localparam int VW = tql_pkg::VALUE_WIDTH;
  localparam int RW = tql_pkg::RATE_W;
  localparam int PW = tql_pkg::PROD_W;
  localparam int SW = tql_pkg::SUM_W;
  localparam int DW = tql_pkg::DIV_W;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_SDONE  = 4'd4;
  localparam logic [3:0] ST_MUL1   = 4'd5;
  localparam logic [3:0] ST_RDCUR  = 4'd6;
  localparam logic [3:0] ST_TD     = 4'd7;
  localparam logic [3:0] ST_MUL2   = 4'd8;
  localparam logic [3:0] ST_WRITE  = 4'd9;

  // saturation bounds of a table value, held at sum width plus one bit
  localparam logic signed [SW:0] Q_MAX = {{(SW-VW+2){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW:0] Q_MIN = {{(SW-VW+2){1'b1}}, {(VW-1){1'b0}}};

  logic [3:0] state;
  logic [RW-1:0] explore_rate, discount, learn_rate;

  // request capture
  logic          mode;
  logic [RW-1:0] rnd;
  logic [tql_pkg::ACTION_W-1:0] act;
  logic [tql_pkg::STATE_W-1:0]  nxt, present_state;
  logic signed [VW-1:0] reward;

  // table memory
  logic signed [VW-1:0] mem [tql_pkg::DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic signed [VW-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // scan / datapath regs
  logic [AW-1:0] clr_cnt;
  logic [tql_pkg::ACTION_W:0] rd_cnt, cmp_cnt;
  logic [tql_pkg::ACTION_W-1:0] best_a;
  logic signed [VW-1:0] best;
  logic signed [SW-1:0] acc;
  logic signed [VW-1:0] cur;
  logic signed [PW-1:0] prod;
  logic [DW-1:0] rem, quo;
  logic [4:0] div_cnt;

  // shared multiplier: signed operand times unsigned 16-bit rate
  logic signed [SW-1:0]   mul_a;
  logic [RW-1:0]          mul_f;
  logic signed [PW-1:0]   mul_p;
  assign mul_p = PW'(mul_a) * $signed({1'b0, mul_f});
  always_comb begin
    mul_a = SW'(best);
    mul_f = discount;
    if (state == ST_MUL2) begin
      mul_a = acc;
      mul_f = learn_rate;
    end
  end

  // floor shift; saturate
  logic signed [PW-17:0] scaled;
  assign scaled = prod[PW-1:16];
  logic signed [SW:0] newq;
  assign newq = (SW+1)'(cur) + (SW+1)'(scaled);
  logic signed [VW-1:0] sat;
  always_comb begin
    if (newq > Q_MAX) sat = Q_MAX[VW-1:0];
    else if (newq < Q_MIN) sat = Q_MIN[VW-1:0];
    else sat = newq[VW-1:0];
  end

  logic out_full;
  logic [3:0] out_data;
  assign m_tvalid = out_full;
  assign m_tdata  = {4'd0, out_data};
  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[3:2])
      tql_pkg::REG_EXPLORE:  prdata = {16'd0, explore_rate};
      tql_pkg::REG_DISCOUNT: prdata = {16'd0, discount};
      tql_pkg::REG_LEARN:    prdata = {16'd0, learn_rate};
      default:               prdata = 32'd0;
    endcase
  end

  // memory port control
  logic [tql_pkg::STATE_W-1:0] scan_row;
  assign scan_row = mode ? nxt : present_state;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    mem_raddr = {scan_row, rd_cnt[tql_pkg::ACTION_W-1:0]};
    if (state == ST_CLEAR) mem_we = 1'b1;
    else if (state == ST_RDCUR || state == ST_TD || state == ST_MUL2) begin
      mem_raddr = {present_state, act};
    end else if (state == ST_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = {present_state, act};
      mem_wdata = sat;
    end
  end

  logic [DW:0] rem_sh;
  assign rem_sh = {rem, quo[DW-1]};
  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      explore_rate  <= tql_pkg::EXPLORE_RESET;
      discount      <= tql_pkg::DISCOUNT_RESET;
      learn_rate    <= tql_pkg::LEARN_RESET;
      present_state <= '0;
      out_full      <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          tql_pkg::REG_EXPLORE:  explore_rate <= pwdata[RW-1:0];
          tql_pkg::REG_DISCOUNT: discount     <= pwdata[RW-1:0];
          tql_pkg::REG_LEARN:    learn_rate   <= pwdata[RW-1:0];
          default: ;
        endcase
      end
      if (state == ST_SDONE && (!out_full || m_tready)) out_full <= 1'b1;
      else if (m_tready) out_full <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (&clr_cnt) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_fire) begin
            mode   <= s_tuser;
            rnd    <= s_tdata[15:0];
            act    <= s_tdata[18:16];
            nxt    <= s_tdata[24:19];
            reward <= s_tdata[56:25];
            rd_cnt <= '0;
            cmp_cnt <= '0;
            if (s_tuser == tql_pkg::MODE_SELECT) begin
              if (s_tdata[15:0] < explore_rate) begin
                rem     <= '0;
                quo     <= {s_tdata[15:0], 3'b000};
                div_cnt <= '0;
                state   <= ST_DIV;
              end else state <= ST_SCAN;
            end else state <= ST_SCAN;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= (DW+1)'(explore_rate)) begin
            rem <= DW'(rem_sh - (DW+1)'(explore_rate));
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= DW'(rem_sh);
            quo <= {quo[DW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DW-1)) state <= ST_SDONE;
        end
        ST_SCAN: begin
          if (!rd_cnt[tql_pkg::ACTION_W]) rd_cnt <= rd_cnt + (tql_pkg::ACTION_W+1)'(1);
          if (rd_cnt != 0) begin
            cmp_cnt <= cmp_cnt + (tql_pkg::ACTION_W+1)'(1);
            if (cmp_cnt == 0 || mem_rdata > best) begin
              best   <= mem_rdata;
              best_a <= cmp_cnt[tql_pkg::ACTION_W-1:0];
            end
            if (cmp_cnt == 4'(tql_pkg::NUM_ACTIONS - 1))
              state <= mode ? ST_MUL1 : ST_SDONE;
          end
        end
        ST_SDONE: begin
          if (!out_full || m_tready) begin
            if (rnd < explore_rate) out_data <= {1'b1, quo[tql_pkg::ACTION_W-1:0]};
            else out_data <= {1'b0, best_a};
            state <= ST_IDLE;
          end
        end
        ST_MUL1: begin
          prod  <= mul_p;
          state <= ST_RDCUR;
        end
        ST_RDCUR: begin
          acc   <= SW'(reward) + SW'(scaled);
          state <= ST_TD;
        end
        ST_TD: begin
          cur   <= mem_rdata;
          acc   <= acc - SW'(mem_rdata);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod  <= mul_p;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          present_state <= nxt;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
